// ----- rtl/spa_pkg.sv -----
package spa_pkg;

	// Default sizes of the stores.
	localparam int MAX_ENTRIES_DEF = 256;
	localparam int IN_ROWS_DEF     = 16;
	localparam int OUT_ROWS_DEF    = 16;

	// Field widths fixed by the interface.
	localparam int ROW_W   = 4;
	localparam int VAL_W   = 16;
	localparam int SUM_W   = 40;
	localparam int ACT_W   = 9;
	localparam int OCNT_W  = 5;
	localparam int CFG_W   = 9;
	localparam int PROD_W  = 48;
	localparam int FRAC_SH = 14;

	// Command codes.
	localparam logic [1:0] CMD_TAB_WR = 2'd0;
	localparam logic [1:0] CMD_V1_WR  = 2'd1;
	localparam logic [1:0] CMD_V2_WR  = 2'd2;
	localparam logic [1:0] CMD_RUN    = 2'd3;

	// Configuration register indexes.
	localparam logic REG_ACTIVE_COUNT = 1'b0;
	localparam logic REG_OUT_COUNT    = 1'b1;

	localparam logic [ACT_W-1:0]  ACTIVE_COUNT_RST = 9'd0;
	localparam logic [OCNT_W-1:0] OUT_COUNT_RST    = 5'd16;

	localparam logic signed [SUM_W-1:0] SUM_MAX = 40'sh7F_FFFF_FFFF;
	localparam logic signed [SUM_W-1:0] SUM_MIN = 40'sh80_0000_0000;

	typedef struct packed {
		logic [ROW_W-1:0]        tgt;
		logic [ROW_W-1:0]        r1;
		logic [ROW_W-1:0]        r2;
		logic signed [VAL_W-1:0] w;
	} tab_ent_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              tab_wr;
		logic              v1_wr;
		logic              v2_wr;
		logic              clr;
		logic              tab_rd;
		logic [ACT_W-1:0]  ent_idx;
		logic              ops_rd;
		logic              mul1;
		logic              mul2;
		logic              acc_wr;
		logic              emit_rd;
		logic [OCNT_W-1:0] emit_idx;
		logic              emit_last;
		logic [OCNT_W-1:0] n_out;
	} ctl_cmd_t;

endpackage

// ----- rtl/spa_ctrl.sv -----
module spa_ctrl #(
	parameter int MAX_ENTRIES = spa_pkg::MAX_ENTRIES_DEF,
	parameter int OUT_ROWS    = spa_pkg::OUT_ROWS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [1:0]               cmd,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [spa_pkg::CFG_W-1:0] cfg_data,
	output logic                     busy,
	output spa_pkg::ctl_cmd_t        ctl
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ENTRY = 3'd1;
	localparam logic [2:0] S_OPS   = 3'd2;
	localparam logic [2:0] S_MUL1  = 3'd3;
	localparam logic [2:0] S_MUL2  = 3'd4;
	localparam logic [2:0] S_ACC   = 3'd5;
	localparam logic [2:0] S_EMIT  = 3'd6;

	logic [2:0]                      state_q, state_d;
	logic [spa_pkg::ACT_W-1:0]       act_cnt_q;
	logic [spa_pkg::OCNT_W-1:0]      out_cnt_q;
	logic [spa_pkg::ACT_W-1:0]       n_act_q, n_act_d;
	logic [spa_pkg::OCNT_W-1:0]      n_out_q, n_out_d;
	logic [spa_pkg::ACT_W-1:0]       ent_q, ent_d;
	logic [spa_pkg::OCNT_W-1:0]      emi_q, emi_d;
	logic                            accept;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_cnt_q <= spa_pkg::ACTIVE_COUNT_RST;
			out_cnt_q <= spa_pkg::OUT_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				spa_pkg::REG_ACTIVE_COUNT: act_cnt_q <= cfg_data;
				spa_pkg::REG_OUT_COUNT:    out_cnt_q <= cfg_data[spa_pkg::OCNT_W-1:0];
				default:                   act_cnt_q <= act_cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_act_q <= '0;
			n_out_q <= '0;
			ent_q   <= '0;
			emi_q   <= '0;
		end else begin
			state_q <= state_d;
			n_act_q <= n_act_d;
			n_out_q <= n_out_d;
			ent_q   <= ent_d;
			emi_q   <= emi_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		n_act_d       = n_act_q;
		n_out_d       = n_out_q;
		ent_d         = ent_q;
		emi_d         = emi_q;
		ctl           = '0;
		ctl.ent_idx   = ent_q;
		ctl.emit_idx  = emi_q;
		ctl.emit_last = (spa_pkg::OCNT_W'(emi_q + 5'd1) == n_out_q);
		ctl.n_out     = n_out_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (cmd)
						spa_pkg::CMD_TAB_WR: ctl.tab_wr = 1'b1;
						spa_pkg::CMD_V1_WR:  ctl.v1_wr  = 1'b1;
						spa_pkg::CMD_V2_WR:  ctl.v2_wr  = 1'b1;
						spa_pkg::CMD_RUN: begin
							ctl.clr = 1'b1;
							n_act_d = (32'(act_cnt_q) > MAX_ENTRIES) ?
								spa_pkg::ACT_W'(MAX_ENTRIES) : act_cnt_q;
							n_out_d = (32'(out_cnt_q) > OUT_ROWS) ?
								spa_pkg::OCNT_W'(OUT_ROWS) : out_cnt_q;
							ent_d   = '0;
							state_d = S_ENTRY;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_ENTRY: begin
				if (ent_q < n_act_q) begin
					ctl.tab_rd = 1'b1;
					state_d    = S_OPS;
				end else begin
					emi_d   = '0;
					state_d = S_EMIT;
				end
			end
			S_OPS: begin
				ctl.ops_rd = 1'b1;
				state_d    = S_MUL1;
			end
			S_MUL1: begin
				ctl.mul1 = 1'b1;
				state_d  = S_MUL2;
			end
			S_MUL2: begin
				ctl.mul2 = 1'b1;
				state_d  = S_ACC;
			end
			S_ACC: begin
				ctl.acc_wr = 1'b1;
				ent_d      = ent_q + 9'd1;
				state_d    = S_ENTRY;
			end
			S_EMIT: begin
				if (emi_q < n_out_q) begin
					ctl.emit_rd = 1'b1;
					emi_d       = emi_q + 5'd1;
				end else begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ----- rtl/spa_dpath.sv -----
module spa_dpath #(
	parameter int MAX_ENTRIES = spa_pkg::MAX_ENTRIES_DEF,
	parameter int IN_ROWS     = spa_pkg::IN_ROWS_DEF,
	parameter int OUT_ROWS    = spa_pkg::OUT_ROWS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  spa_pkg::ctl_cmd_t                 ctl,
	input  logic [7:0]                        entry_slot,
	input  logic [spa_pkg::ROW_W-1:0]         target_row,
	input  logic [spa_pkg::ROW_W-1:0]         first_row,
	input  logic [spa_pkg::ROW_W-1:0]         second_row,
	input  logic signed [spa_pkg::VAL_W-1:0]  weight,
	input  logic [spa_pkg::ROW_W-1:0]         element_pos,
	input  logic signed [spa_pkg::VAL_W-1:0]  element_value,
	output logic                              result_valid,
	output logic [spa_pkg::ROW_W-1:0]         result_row,
	output logic signed [spa_pkg::SUM_W-1:0]  row_sum,
	output logic                              last
);

	localparam int ENT_AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int IN_AW  = (IN_ROWS > 1) ? $clog2(IN_ROWS) : 1;
	localparam int OUT_AW = (OUT_ROWS > 1) ? $clog2(OUT_ROWS) : 1;

	spa_pkg::tab_ent_t               tab_mem [MAX_ENTRIES];
	logic signed [spa_pkg::VAL_W-1:0] v1_mem [IN_ROWS];
	logic signed [spa_pkg::VAL_W-1:0] v2_mem [IN_ROWS];
	logic signed [spa_pkg::SUM_W-1:0] sum_mem [OUT_ROWS];
	logic [OUT_ROWS-1:0]             sum_vld_q;

	spa_pkg::tab_ent_t               tab_q;
	logic signed [spa_pkg::VAL_W-1:0] a_q, b_q, w_q;
	logic                            r1_ok_q, r2_ok_q, use_q;
	logic [spa_pkg::ROW_W-1:0]       tgt_q;
	logic signed [spa_pkg::SUM_W-1:0] sum_rd_q;
	logic                            sum_rd_vld_q;
	logic signed [2*spa_pkg::VAL_W-1:0] ab_s1;
	logic signed [spa_pkg::VAL_W-1:0] w_s1;
	logic signed [spa_pkg::PROD_W-1:0] prod_s2;

	logic [OUT_AW-1:0]               sum_raddr;
	logic signed [spa_pkg::VAL_W-1:0] a_op, b_op;
	logic signed [spa_pkg::PROD_W-spa_pkg::FRAC_SH-1:0] inc;
	logic signed [spa_pkg::SUM_W-1:0] cur;
	logic signed [spa_pkg::SUM_W:0]  acc_wide;
	logic signed [spa_pkg::SUM_W-1:0] acc_sat;

	logic                            emit_vld_s1, emit_last_s1;
	logic [spa_pkg::ROW_W-1:0]       emit_row_s1;

	// Entry table and input vectors.
	always_ff @(posedge clk) begin
		if (ctl.tab_wr && (32'(entry_slot) < MAX_ENTRIES)) begin
			tab_mem[ENT_AW'(entry_slot)] <= '{target_row, first_row, second_row, weight};
		end
		if (ctl.tab_rd) begin
			tab_q <= tab_mem[ENT_AW'(ctl.ent_idx)];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.v1_wr && (32'(element_pos) < IN_ROWS)) begin
			v1_mem[IN_AW'(element_pos)] <= element_value;
		end
		if (ctl.v2_wr && (32'(element_pos) < IN_ROWS)) begin
			v2_mem[IN_AW'(element_pos)] <= element_value;
		end
		if (ctl.ops_rd) begin
			a_q     <= v1_mem[IN_AW'(tab_q.r1)];
			b_q     <= v2_mem[IN_AW'(tab_q.r2)];
			r1_ok_q <= (32'(tab_q.r1) < IN_ROWS);
			r2_ok_q <= (32'(tab_q.r2) < IN_ROWS);
			w_q     <= tab_q.w;
			tgt_q   <= tab_q.tgt;
			use_q   <= ({1'b0, tab_q.tgt} < ctl.n_out);
		end
	end

	// Row sums: one read port shared by the accumulate and emit phases.
	assign sum_raddr = ctl.emit_rd ? OUT_AW'(ctl.emit_idx) : OUT_AW'(tab_q.tgt);

	always_ff @(posedge clk) begin
		if (ctl.acc_wr && use_q) begin
			sum_mem[OUT_AW'(tgt_q)] <= acc_sat;
		end
		if (ctl.ops_rd || ctl.emit_rd) begin
			sum_rd_q <= sum_mem[sum_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_vld_q    <= '0;
			sum_rd_vld_q <= 1'b0;
		end else begin
			if (ctl.clr) begin
				sum_vld_q <= '0;
			end else if (ctl.acc_wr && use_q) begin
				sum_vld_q[OUT_AW'(tgt_q)] <= 1'b1;
			end
			if (ctl.ops_rd || ctl.emit_rd) begin
				sum_rd_vld_q <= sum_vld_q[sum_raddr];
			end
		end
	end

	// Products: two multiplier stages.
	assign a_op = r1_ok_q ? a_q : '0;
	assign b_op = r2_ok_q ? b_q : '0;

	always_ff @(posedge clk) begin
		if (ctl.mul1) begin
			ab_s1 <= a_op * b_op;
			w_s1  <= w_q;
		end
		if (ctl.mul2) begin
			prod_s2 <= ab_s1 * w_s1;
		end
	end

	// Scale, add and saturate.
	assign inc      = prod_s2[spa_pkg::PROD_W-1:spa_pkg::FRAC_SH];
	assign cur      = sum_rd_vld_q ? sum_rd_q : '0;
	assign acc_wide = {cur[spa_pkg::SUM_W-1], cur}
		+ {{(spa_pkg::SUM_W + 1 - $bits(inc)){inc[$bits(inc)-1]}}, inc};

	always_comb begin
		if (acc_wide[spa_pkg::SUM_W] != acc_wide[spa_pkg::SUM_W-1]) begin
			acc_sat = acc_wide[spa_pkg::SUM_W] ? spa_pkg::SUM_MIN : spa_pkg::SUM_MAX;
		end else begin
			acc_sat = acc_wide[spa_pkg::SUM_W-1:0];
		end
	end

	// Result stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_vld_s1  <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			emit_vld_s1  <= ctl.emit_rd;
			result_valid <= emit_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		emit_row_s1  <= spa_pkg::ROW_W'(ctl.emit_idx);
		emit_last_s1 <= ctl.emit_last;
		result_row   <= emit_row_s1;
		last         <= emit_last_s1;
		row_sum      <= cur;
	end

endmodule

// ----- rtl/sparse_product_accumulate_core.sv -----
// Load commands (table entry, first or second vector element) never raise busy.
// A compute command keeps busy high until every active entry and output row is done;
// each table entry walks a five-step sequence through one shared multiply path.
// Results appear one per cycle, one cycle wide, via the sum read and output registers.
// Reset restores the control state and configuration; table and vectors hold no reset.
// The receiver cannot stall: every result is a transfer in the cycle it is shown.
module sparse_product_accumulate_core #(
	parameter int MAX_ENTRIES = spa_pkg::MAX_ENTRIES_DEF,
	parameter int IN_ROWS     = spa_pkg::IN_ROWS_DEF,
	parameter int OUT_ROWS    = spa_pkg::OUT_ROWS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        cmd,
	input  logic [7:0]                        entry_slot,
	input  logic [spa_pkg::ROW_W-1:0]         target_row,
	input  logic [spa_pkg::ROW_W-1:0]         first_row,
	input  logic [spa_pkg::ROW_W-1:0]         second_row,
	input  logic signed [spa_pkg::VAL_W-1:0]  weight,
	input  logic [spa_pkg::ROW_W-1:0]         element_pos,
	input  logic signed [spa_pkg::VAL_W-1:0]  element_value,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [spa_pkg::CFG_W-1:0]         cfg_data,
	output logic                              result_valid,
	output logic [spa_pkg::ROW_W-1:0]         result_row,
	output logic signed [spa_pkg::SUM_W-1:0]  row_sum,
	output logic                              last
);

	// The controller sequences each transfer: load commands write a store in the
	// cycle they are accepted, and a compute command clears the row sums, then
	// for every active entry reads the table, reads both vector elements and the
	// running sum, multiplies twice, writes back a saturated sum and then emits each row.
	spa_pkg::ctl_cmd_t ctl;

	spa_ctrl #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.OUT_ROWS    (OUT_ROWS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.busy      (busy),
		.ctl       (ctl)
	);

	// The datapath holds the table, vectors and row sums, plus the multiply and
	// saturating accumulate stages and the registered result outputs.
	spa_dpath #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.IN_ROWS     (IN_ROWS),
		.OUT_ROWS    (OUT_ROWS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.entry_slot    (entry_slot),
		.target_row    (target_row),
		.first_row     (first_row),
		.second_row    (second_row),
		.weight        (weight),
		.element_pos   (element_pos),
		.element_value (element_value),
		.result_valid  (result_valid),
		.result_row    (result_row),
		.row_sum       (row_sum),
		.last          (last)
	);

endmodule
